// ----- rtl/round_robin_thread_scheduler_assert.svh -----
// Assertion macros for the round-robin thread scheduler.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is high.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

// ----- rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin thread scheduler.
// Depends on nothing; imported by the scheduler top level.
package rrts_pkg;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] stack_size;
      logic [31:0] saved_sp;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  created_thread;
      logic [31:0] created_stack_top;
      logic [2:0]  next_thread;
      logic [31:0] next_context_sp;
   } rsp_type;

   // Request action codes.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_RUN   = 2'd1;
   localparam logic [1:0] ACT_EXIT  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NOSLOT = 2'd1;
   localparam logic [1:0] STAT_DOWN   = 2'd2;

   // Size of the saved register frame below a new thread's stack top.
   localparam logic [31:0] CTX_FRAME_BYTES = 32'd36;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_NEWT,
      ST_HEAD,
      ST_CTX,
      ST_LOAD
   } state_type;

endpackage

// ----- rtl/round_robin_thread_scheduler.sv -----
// Round-robin thread scheduler: a start or system-down result is loaded right after the
// execute state, exit, no-slot run or idle action after the head and context reads, a
// creating run after the new-thread state too; a new request is taken only when idle.
// A finished result waits in an output register while the next request is taken.
// Reset (synchronous, active high) frees all slots, empties the queue, clears
// stack_base and leaves the system down until a start request.
module round_robin_thread_scheduler #(
   parameter int THREAD_SLOTS = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrts_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data
);
   import rrts_pkg::*;

   // Slot index, queue count and wrap-sum widths.
   localparam int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int CW = $clog2(THREAD_SLOTS + 1);
   localparam int SW = CW + 1;

   // Queue position after a head index plus an offset, wrapped once.
   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                             input logic [CW-1:0] b);
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b);
      if (s >= SW'(THREAD_SLOTS)) begin
         s = s - SW'(THREAD_SLOTS);
      end
      return IW'(s);
   endfunction

   // Control state.
   state_type           state_ff, state_in;
   logic [THREAD_SLOTS-1:0] slot_use_ff, slot_use_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [31:0]         stack_next_ff, stack_next_in;
   logic                halted_ff, halted_in;
   logic [31:0]         stack_base_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   req_type             req_ff;
   rsp_type             res_ff, res_in;
   logic                use_mem_ff, use_mem_in;
   logic [IW-1:0]       new_slot_ff, new_slot_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // The two memories: the ready queue of slot indexes and the saved contexts.
   logic [IW-1:0]       fifo_mem [THREAD_SLOTS];
   logic [31:0]         ctx_mem  [THREAD_SLOTS];
   logic [IW-1:0]       fifo_rdata_ff;
   logic [31:0]         ctx_rdata_ff;
   logic                fifo_we, fifo_re, ctx_we, ctx_re;
   logic [IW-1:0]       fifo_waddr, fifo_raddr, ctx_waddr, ctx_raddr;
   logic [IW-1:0]       fifo_wdata;
   logic [31:0]         ctx_wdata;

   // Lowest free slot, searched over the in-use bits.
   logic                free_found;
   logic [IW-1:0]       free_slot;
   logic [IW-1:0]       cur_slot;
   logic [IW-1:0]       head_inc;
   logic [31:0]         start_top;
   logic [31:0]         run_top;
   logic                out_free;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
         if (!slot_use_ff[i]) begin
            free_found = 1'b1;
            free_slot  = IW'(i);
         end
      end
   end

   // The head entry was read in the accept cycle, so it is the current thread here.
   assign cur_slot  = fifo_rdata_ff;
   assign head_inc  = (head_ff == IW'(THREAD_SLOTS - 1)) ? '0 : head_ff + 1'b1;
   assign start_top = stack_base_ff + 32'(req_ff.stack_size);
   assign run_top   = stack_next_ff + 32'(req_ff.stack_size);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next-state logic of the request sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.action == ACT_START || halted_ff) begin
               state_in = ST_LOAD;
            end else begin
               unique case (req_ff.action)
                  ACT_RUN: begin
                     if (free_found) begin
                        state_in = ST_NEWT;
                     end else if (count_ff == CW'(1)) begin
                        state_in = ST_LOAD;
                     end else begin
                        state_in = ST_HEAD;
                     end
                  end
                  ACT_EXIT: begin
                     state_in = (count_ff == CW'(1)) ? ST_LOAD : ST_HEAD;
                  end
                  default: begin
                     state_in = ST_HEAD;
                  end
               endcase
            end
         end
         ST_NEWT: state_in = ST_HEAD;
         ST_HEAD: state_in = ST_CTX;
         ST_CTX:  state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control for each sequencer state.
   always_comb begin
      slot_use_in   = slot_use_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      stack_next_in = stack_next_ff;
      halted_in     = halted_ff;
      res_in        = res_ff;
      use_mem_in    = use_mem_ff;
      new_slot_in   = new_slot_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      fifo_we       = 1'b0;
      fifo_waddr    = '0;
      fifo_wdata    = '0;
      fifo_re       = 1'b0;
      fifo_raddr    = head_ff;
      ctx_we        = 1'b0;
      ctx_waddr     = '0;
      ctx_wdata     = '0;
      ctx_re        = 1'b0;
      ctx_raddr     = fifo_rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Fetch the queue head so the current thread is known next cycle.
            fifo_re = 1'b1;
         end
         ST_EXEC: begin
            res_in     = '0;
            use_mem_in = 1'b0;
            if (req_ff.action == ACT_START) begin
               // Start rebuilds the system around thread zero.
               slot_use_in   = '0;
               slot_use_in[0] = 1'b1;
               head_in       = '0;
               count_in      = CW'(1);
               stack_next_in = start_top;
               halted_in     = 1'b0;
               ctx_we        = 1'b1;
               ctx_waddr     = '0;
               ctx_wdata     = start_top - CTX_FRAME_BYTES;
               fifo_we       = 1'b1;
               fifo_waddr    = '0;
               fifo_wdata    = '0;
               res_in.status            = STAT_OK;
               res_in.created_stack_top = start_top;
               res_in.next_context_sp   = start_top - CTX_FRAME_BYTES;
            end else if (halted_ff) begin
               res_in.status = STAT_DOWN;
            end else begin
               unique case (req_ff.action)
                  ACT_RUN: begin
                     // Save the caller's context and take it off the head.
                     ctx_we    = 1'b1;
                     ctx_waddr = cur_slot;
                     ctx_wdata = req_ff.saved_sp;
                     head_in   = head_inc;
                     if (free_found) begin
                        // Caller goes back to the tail; the count stays until
                        // the new thread joins behind it.
                        slot_use_in[free_slot] = 1'b1;
                        stack_next_in = run_top;
                        new_slot_in   = free_slot;
                        fifo_we       = 1'b1;
                        fifo_waddr    = wrap_add(head_ff, count_ff);
                        fifo_wdata    = cur_slot;
                        res_in.status            = STAT_OK;
                        res_in.created_thread    = 3'(free_slot);
                        res_in.created_stack_top = run_top;
                        use_mem_in = 1'b1;
                     end else begin
                        // No slot: the caller is dropped but keeps its slot.
                        count_in = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           halted_in     = 1'b1;
                           res_in.status = STAT_DOWN;
                        end else begin
                           res_in.status = STAT_NOSLOT;
                           use_mem_in    = 1'b1;
                        end
                     end
                  end
                  ACT_EXIT: begin
                     // The exiting thread's context is never read again.
                     slot_use_in[cur_slot] = 1'b0;
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                     if (count_ff == CW'(1)) begin
                        halted_in     = 1'b1;
                        res_in.status = STAT_DOWN;
                     end else begin
                        use_mem_in = 1'b1;
                     end
                  end
                  default: begin
                     use_mem_in = 1'b1;
                  end
               endcase
            end
         end
         ST_NEWT: begin
            // The new thread's frame and its place behind the caller.
            ctx_we     = 1'b1;
            ctx_waddr  = new_slot_ff;
            ctx_wdata  = stack_next_ff - CTX_FRAME_BYTES;
            fifo_we    = 1'b1;
            fifo_waddr = wrap_add(head_ff, count_ff);
            fifo_wdata = new_slot_ff;
            count_in   = count_ff + 1'b1;
         end
         ST_HEAD: begin
            fifo_re    = 1'b1;
            fifo_raddr = head_ff;
         end
         ST_CTX: begin
            ctx_re    = 1'b1;
            ctx_raddr = fifo_rdata_ff;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               if (use_mem_ff) begin
                  rsp_data_in.next_thread     = 3'(fifo_rdata_ff);
                  rsp_data_in.next_context_sp = ctx_rdata_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
      if (fifo_re) begin
         fifo_rdata_ff <= fifo_mem[fifo_raddr];
      end
      if (ctx_we) begin
         ctx_mem[ctx_waddr] <= ctx_wdata;
      end
      if (ctx_re) begin
         ctx_rdata_ff <= ctx_mem[ctx_raddr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      res_ff      <= res_in;
      use_mem_ff  <= use_mem_in;
      new_slot_ff <= new_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_use_ff   <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         stack_next_ff <= '0;
         halted_ff     <= 1'b1;
         stack_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_use_ff   <= slot_use_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         stack_next_ff <= stack_next_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            stack_base_ff <= csr_write_data;
         end
      end
   end

`include "round_robin_thread_scheduler_assert.svh"

   // A running system never waits for a request with an empty queue.
   `RRTS_ASSERT_NOW(a_live_queue, clock, reset,
      state_ff == ST_IDLE && !halted_ff, count_ff != '0)
   // Every queued thread holds a slot of its own.
   `RRTS_ASSERT_NOW(a_count_slots, clock, reset,
      1'b1, 32'(count_ff) <= 32'($countones(slot_use_ff)))
   // A result waiting on a stalled output is neither lost nor overwritten.
   `RRTS_ASSERT_NEXT(a_load_hold, clock, reset,
      state_ff == ST_LOAD && rsp_valid_ff && !rsp_ready,
      state_ff == ST_LOAD && $stable(rsp_data_ff))
   // A system-down result never names a thread.
   `RRTS_ASSERT_NOW(a_down_empty, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == STAT_DOWN,
      rsp_data_ff.next_thread == '0 && rsp_data_ff.next_context_sp == '0)

endmodule
